### src/tasc_pkg.sv
// ----------------------------------------------------------------------------
// tasc_pkg: shared types and constants of the two-axis servo controller
// widths of the command fields, reset values, op codes and register indexes
// ----------------------------------------------------------------------------
package tasc_pkg;

    // field widths
    localparam int PWM_W   = 12;
    localparam int GAIN_W  = 16;
    localparam int DZ_W    = 12;
    localparam int STEP_W  = 11;
    localparam int ERR_W   = 13;
    localparam int OP_W    = 2;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    // gain fraction bits and default position fraction bits
    localparam int GAIN_FRAC             = 12;
    localparam int DEFAULT_POS_FRAC_BITS = 8;

    // centre and reset positions, in pwm counts
    localparam int CENTER_PWM  = 1500;
    localparam int RESET_PWM_X = 1550;
    localparam int RESET_PWM_Y = 1500;

    // register reset values
    localparam logic signed [GAIN_W-1:0] RST_KP_YAW   = -16'sd205;
    localparam logic signed [GAIN_W-1:0] RST_KD_YAW   = -16'sd5939;
    localparam logic signed [GAIN_W-1:0] RST_KP_PITCH = 16'sd205;
    localparam logic signed [GAIN_W-1:0] RST_KD_PITCH = 16'sd5939;
    localparam logic [DZ_W-1:0]          RST_DEAD_ZONE = 12'd5;
    localparam logic [STEP_W-1:0]        RST_MAX_STEP  = 11'd45;
    localparam logic [PWM_W-1:0]         RST_PWM_UPPER = 12'd2500;
    localparam logic [PWM_W-1:0]         RST_PWM_LOWER = 12'd500;

    typedef enum logic [OP_W-1:0] {
        OP_PD_STEP   = 2'd0,
        OP_CENTRE    = 2'd1,
        OP_LOAD      = 2'd2,
        OP_CLEAR_ERR = 2'd3
    } op_t;

    typedef enum logic [CFG_A_W-1:0] {
        REG_KP_YAW    = 3'd0,
        REG_KD_YAW    = 3'd1,
        REG_KP_PITCH  = 3'd2,
        REG_KD_PITCH  = 3'd3,
        REG_DEAD_ZONE = 3'd4,
        REG_MAX_STEP  = 3'd5,
        REG_PWM_UPPER = 3'd6,
        REG_PWM_LOWER = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp_yaw;
        logic signed [GAIN_W-1:0] kd_yaw;
        logic signed [GAIN_W-1:0] kp_pitch;
        logic signed [GAIN_W-1:0] kd_pitch;
        logic [DZ_W-1:0]          dead_zone;
        logic [STEP_W-1:0]        max_step;
        logic [PWM_W-1:0]         pwm_upper;
        logic [PWM_W-1:0]         pwm_lower;
    } tasc_cfg_t;

endpackage

### src/two_axis_servo_pd_slew_controller.sv
// ----------------------------------------------------------------------------
// two_axis_servo_pd_slew_controller: two-axis servo position controller
// incremental pd with dead zone and slew limit, centring, loading and clearing
// ----------------------------------------------------------------------------
//
// channel   direction  tdata                                  tuser
// s_axis    in         measured, target, load_pwm_x/y (48b)    op, axis (3b)
// m_axis    out        pwm_x, pwm_y (24b)                     -
// cfg       in         cfg_addr selects register, cfg_wdata   -
//
// one command beat per cycle while m_axis_tready keeps the result register
// emptying; a beat passes through the input register, then the result register
// axis state (positions, last errors) updates as a beat moves from the input
// register into the result register, so the next beat always sees it
// a held result stalls the input register only; the input side still takes a
// beat in the same cycle that the result register is emptied
// reset (aresetn low, synchronous) restores positions, errors and registers
// ----------------------------------------------------------------------------
module two_axis_servo_pd_slew_controller
    import tasc_pkg::*;
#(
    parameter int POS_FRAC_BITS = DEFAULT_POS_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,

    // command stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: measured[11:0], target[23:12], load_pwm_x[35:24], load_pwm_y[47:36]
    input  logic [47:0]        s_axis_tdata,
    // tuser: op[1:0], axis[2]
    input  logic [2:0]         s_axis_tuser,

    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // tdata: pwm_x[11:0], pwm_y[23:12]
    output logic [23:0]        m_axis_tdata,

    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_D_W-1:0] cfg_wdata
);

    localparam int POS_W = PWM_W + POS_FRAC_BITS;
    localparam int IN_W  = 4 * PWM_W;
    localparam int USR_W = OP_W + 1;

    tasc_cfg_t cfg;

    // input register
    logic             in_valid_reg;
    logic [IN_W-1:0]  in_data_reg;
    logic [USR_W-1:0] in_user_reg;

    // result register
    logic             out_valid_reg;
    logic [23:0]      out_data_reg;

    // axis state
    logic [POS_W-1:0]        pos_x_reg,  pos_y_reg;
    logic [POS_W-1:0]        pos_x_next, pos_y_next;
    logic signed [ERR_W-1:0] prev_x_reg,  prev_y_reg;
    logic signed [ERR_W-1:0] prev_x_next, prev_y_next;

    logic advance;

    // unpacked command fields
    op_t              op;
    logic             axis;
    logic [PWM_W-1:0] measured, target, load_pwm_x, load_pwm_y;

    // pd unit inputs, steered by axis
    logic [POS_W-1:0]         pd_pos;
    logic signed [ERR_W-1:0]  pd_prev;
    logic signed [GAIN_W-1:0] pd_kp, pd_kd;
    logic [POS_W-1:0]         pd_pos_new;
    logic signed [ERR_W-1:0]  pd_err_new;

    logic [POS_W-1:0] ctr_x_new, ctr_y_new;

    assign cfg_ready = 1'b1;

    tasc_cfg_regs u_cfg (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (cfg_valid),
        .wr_addr(cfg_addr),
        .wr_data(cfg_wdata),
        .cfg    (cfg)
    );

    // the input register moves on when the result register is free or emptying
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= s_axis_tdata;
            in_user_reg <= s_axis_tuser;
        end
    end

    assign op         = op_t'(in_user_reg[OP_W-1:0]);
    assign axis       = in_user_reg[OP_W];
    assign measured   = in_data_reg[PWM_W-1:0];
    assign target     = in_data_reg[2*PWM_W-1:PWM_W];
    assign load_pwm_x = in_data_reg[3*PWM_W-1:2*PWM_W];
    assign load_pwm_y = in_data_reg[4*PWM_W-1:3*PWM_W];

    // one pd unit shared by both axes
    assign pd_pos  = axis ? pos_y_reg    : pos_x_reg;
    assign pd_prev = axis ? prev_y_reg   : prev_x_reg;
    assign pd_kp   = axis ? cfg.kp_pitch : cfg.kp_yaw;
    assign pd_kd   = axis ? cfg.kd_pitch : cfg.kd_yaw;

    tasc_pd_unit #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_pd (
        .pos      (pd_pos),
        .prev_err (pd_prev),
        .kp       (pd_kp),
        .kd       (pd_kd),
        .measured (measured),
        .target   (target),
        .dead_zone(cfg.dead_zone),
        .max_step (cfg.max_step),
        .pwm_upper(cfg.pwm_upper),
        .pwm_lower(cfg.pwm_lower),
        .pos_new  (pd_pos_new),
        .err_new  (pd_err_new)
    );

    // centring runs on both axes at once
    tasc_centre_unit #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_centre_x (
        .pos      (pos_x_reg),
        .max_step (cfg.max_step),
        .pwm_upper(cfg.pwm_upper),
        .pwm_lower(cfg.pwm_lower),
        .pos_new  (ctr_x_new)
    );

    tasc_centre_unit #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_centre_y (
        .pos      (pos_y_reg),
        .max_step (cfg.max_step),
        .pwm_upper(cfg.pwm_upper),
        .pwm_lower(cfg.pwm_lower),
        .pos_new  (ctr_y_new)
    );

    // next axis state for the command in the input register
    always_comb begin
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        case (op)
            OP_PD_STEP: begin
                if (axis) begin
                    pos_y_next  = pd_pos_new;
                    prev_y_next = pd_err_new;
                end else begin
                    pos_x_next  = pd_pos_new;
                    prev_x_next = pd_err_new;
                end
            end
            OP_CENTRE: begin
                pos_x_next  = ctr_x_new;
                pos_y_next  = ctr_y_new;
                prev_x_next = '0;
                prev_y_next = '0;
            end
            OP_LOAD: begin
                // loaded as is, no clamp to the limits
                pos_x_next = POS_W'(load_pwm_x) << POS_FRAC_BITS;
                pos_y_next = POS_W'(load_pwm_y) << POS_FRAC_BITS;
            end
            OP_CLEAR_ERR: begin
                prev_x_next = '0;
                prev_y_next = '0;
            end
            default: begin
                pos_x_next = pos_x_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg  <= POS_W'(RESET_PWM_X) << POS_FRAC_BITS;
            pos_y_reg  <= POS_W'(RESET_PWM_Y) << POS_FRAC_BITS;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end else if (advance) begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
        end
    end

    // result register: integer parts of the updated positions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {pos_y_next[POS_W-1:POS_FRAC_BITS],
                             pos_x_next[POS_W-1:POS_FRAC_BITS]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### src/tasc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tasc_cfg_regs: configuration register file
// gains, dead zone, step limit and pwm limits, written one register per beat
// ----------------------------------------------------------------------------
module tasc_cfg_regs
    import tasc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [CFG_A_W-1:0] wr_addr,
    input  logic [CFG_D_W-1:0] wr_data,
    output tasc_cfg_t          cfg
);

    tasc_cfg_t cfg_reg;
    tasc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfg_index_t'(wr_addr))
                REG_KP_YAW:    cfg_next.kp_yaw    = $signed(wr_data);
                REG_KD_YAW:    cfg_next.kd_yaw    = $signed(wr_data);
                REG_KP_PITCH:  cfg_next.kp_pitch  = $signed(wr_data);
                REG_KD_PITCH:  cfg_next.kd_pitch  = $signed(wr_data);
                REG_DEAD_ZONE: cfg_next.dead_zone = wr_data[DZ_W-1:0];
                REG_MAX_STEP:  cfg_next.max_step  = wr_data[STEP_W-1:0];
                REG_PWM_UPPER: cfg_next.pwm_upper = wr_data[PWM_W-1:0];
                REG_PWM_LOWER: cfg_next.pwm_lower = wr_data[PWM_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_yaw    <= RST_KP_YAW;
            cfg_reg.kd_yaw    <= RST_KD_YAW;
            cfg_reg.kp_pitch  <= RST_KP_PITCH;
            cfg_reg.kd_pitch  <= RST_KD_PITCH;
            cfg_reg.dead_zone <= RST_DEAD_ZONE;
            cfg_reg.max_step  <= RST_MAX_STEP;
            cfg_reg.pwm_upper <= RST_PWM_UPPER;
            cfg_reg.pwm_lower <= RST_PWM_LOWER;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/tasc_limit_clamp.sv
// ----------------------------------------------------------------------------
// tasc_limit_clamp: clamp a position to the pwm limits
// upper limit first, then lower, so inverted limits settle on the lower one
// ----------------------------------------------------------------------------
module tasc_limit_clamp
    import tasc_pkg::*;
#(
    parameter int POS_FRAC_BITS = DEFAULT_POS_FRAC_BITS
) (
    input  logic signed [PWM_W+POS_FRAC_BITS+1:0] pos_in,
    input  logic [PWM_W-1:0]                      pwm_upper,
    input  logic [PWM_W-1:0]                      pwm_lower,
    output logic [PWM_W+POS_FRAC_BITS-1:0]        pos_out
);

    localparam int POS_W = PWM_W + POS_FRAC_BITS;
    localparam int P_W   = POS_W + 2;

    logic signed [P_W-1:0] upper_pos;
    logic signed [P_W-1:0] lower_pos;
    logic signed [P_W-1:0] after_upper;
    logic signed [P_W-1:0] after_lower;

    assign upper_pos = $signed(P_W'(pwm_upper) << POS_FRAC_BITS);
    assign lower_pos = $signed(P_W'(pwm_lower) << POS_FRAC_BITS);

    assign after_upper = (pos_in > upper_pos) ? upper_pos : pos_in;
    assign after_lower = (after_upper < lower_pos) ? lower_pos : after_upper;

    // the result always lies inside the unsigned position range
    assign pos_out = after_lower[POS_W-1:0];

endmodule

### src/tasc_pd_unit.sv
// ----------------------------------------------------------------------------
// tasc_pd_unit: one incremental pd step on the selected axis
// dead zone, kp*e + kd*(e - prev), rounding to position format, pwm clamp after the step limit
// ----------------------------------------------------------------------------
module tasc_pd_unit
    import tasc_pkg::*;
#(
    parameter int POS_FRAC_BITS = DEFAULT_POS_FRAC_BITS
) (
    input  logic [PWM_W+POS_FRAC_BITS-1:0]  pos,
    input  logic signed [ERR_W-1:0]         prev_err,
    input  logic signed [GAIN_W-1:0]        kp,
    input  logic signed [GAIN_W-1:0]        kd,
    input  logic [PWM_W-1:0]                measured,
    input  logic [PWM_W-1:0]                target,
    input  logic [DZ_W-1:0]                 dead_zone,
    input  logic [STEP_W-1:0]               max_step,
    input  logic [PWM_W-1:0]                pwm_upper,
    input  logic [PWM_W-1:0]                pwm_lower,
    output logic [PWM_W+POS_FRAC_BITS-1:0]  pos_new,
    output logic signed [ERR_W-1:0]         err_new
);

    localparam int POS_W  = PWM_W + POS_FRAC_BITS;
    localparam int P_W    = POS_W + 2;
    localparam int D_W    = STEP_W + POS_FRAC_BITS + 1;
    localparam int DERR_W = ERR_W + 1;
    localparam int PT_W   = GAIN_W + ERR_W;
    localparam int DT_W   = GAIN_W + DERR_W;
    localparam int SUM_W  = DT_W + 1;
    localparam int SH     = GAIN_FRAC - POS_FRAC_BITS;
    localparam int HALF   = (SH > 0) ? (1 << (SH - 1)) : 0;

    logic signed [ERR_W-1:0]  err_raw;
    logic signed [ERR_W:0]    err_wide;
    logic signed [ERR_W:0]    dz_s;
    logic                     in_dz;
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;
    logic signed [PT_W-1:0]   p_term;
    logic signed [DT_W-1:0]   d_term;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  shifted;
    logic [D_W-1:0]           lim;
    logic signed [SUM_W-1:0]  lim_s;
    logic signed [D_W-1:0]    delta;
    logic signed [P_W-1:0]    pos_sum;

    // error and dead zone
    assign err_raw  = $signed({1'b0, target}) - $signed({1'b0, measured});
    assign err_wide = {err_raw[ERR_W-1], err_raw};
    assign dz_s     = $signed((ERR_W+1)'(dead_zone));
    assign in_dz    = (err_wide > -dz_s) && (err_wide < dz_s);
    assign err      = in_dz ? '0 : err_raw;
    assign err_new  = err;

    // pd sum, exact in gain format
    assign derr   = DERR_W'(err) - DERR_W'(prev_err);
    assign p_term = kp * err;
    assign d_term = kd * derr;
    assign sum    = SUM_W'(p_term) + SUM_W'(d_term) + SUM_W'(HALF);

    // round half up into position format
    assign shifted = sum >>> SH;

    // step limit
    assign lim   = D_W'(max_step) << POS_FRAC_BITS;
    assign lim_s = $signed(SUM_W'(lim));

    always_comb begin
        if (shifted > lim_s) begin
            delta = $signed(lim);
        end else if (shifted < -lim_s) begin
            delta = -$signed(lim);
        end else begin
            delta = shifted[D_W-1:0];
        end
    end

    assign pos_sum = $signed(P_W'(pos)) + P_W'(delta);

    tasc_limit_clamp #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_clamp (
        .pos_in   (pos_sum),
        .pwm_upper(pwm_upper),
        .pwm_lower(pwm_lower),
        .pos_out  (pos_new)
    );

endmodule

### src/tasc_centre_unit.sv
// ----------------------------------------------------------------------------
// tasc_centre_unit: slew one axis toward the centre position
// step limited move, snap to centre within one count, then pwm limits
// ----------------------------------------------------------------------------
module tasc_centre_unit
    import tasc_pkg::*;
#(
    parameter int POS_FRAC_BITS = DEFAULT_POS_FRAC_BITS
) (
    input  logic [PWM_W+POS_FRAC_BITS-1:0]  pos,
    input  logic [STEP_W-1:0]               max_step,
    input  logic [PWM_W-1:0]                pwm_upper,
    input  logic [PWM_W-1:0]                pwm_lower,
    output logic [PWM_W+POS_FRAC_BITS-1:0]  pos_new
);

    localparam int POS_W = PWM_W + POS_FRAC_BITS;
    localparam int C_W   = POS_W + 1;
    localparam int P_W   = POS_W + 2;
    localparam int D_W   = STEP_W + POS_FRAC_BITS + 1;

    logic signed [C_W-1:0] centre;
    logic signed [C_W-1:0] diff;
    logic [D_W-1:0]        lim;
    logic signed [C_W-1:0] lim_s;
    logic signed [D_W-1:0] delta;
    logic signed [D_W-1:0] one_s;
    logic                  near;
    logic signed [P_W-1:0] pos_sum;

    assign centre = $signed(C_W'(CENTER_PWM) << POS_FRAC_BITS);
    assign diff   = centre - $signed(C_W'(pos));

    assign lim   = D_W'(max_step) << POS_FRAC_BITS;
    assign lim_s = $signed(C_W'(lim));

    always_comb begin
        if (diff > lim_s) begin
            delta = $signed(lim);
        end else if (diff < -lim_s) begin
            delta = -$signed(lim);
        end else begin
            delta = diff[D_W-1:0];
        end
    end

    // step-limited move under one count: go straight to the centre
    assign one_s   = $signed(D_W'(1) << POS_FRAC_BITS);
    assign near    = (delta > -one_s) && (delta < one_s);
    assign pos_sum = near ? P_W'(centre) : ($signed(P_W'(pos)) + P_W'(delta));

    tasc_limit_clamp #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_clamp (
        .pos_in   (pos_sum),
        .pwm_upper(pwm_upper),
        .pwm_lower(pwm_lower),
        .pos_out  (pos_new)
    );

endmodule
